// File: hdl/assert_macros.svh
// Assertion macros shared by the header field delimiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MHFD_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("mhfd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MHFD_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("mhfd: next-cycle check failed");

`endif

// File: hdl/mhfd_pkg.sv
// Package: constants, types and helpers of the mail header field delimiter.
`timescale 1ns / 1ps
package mhfd_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	typedef enum logic [3:0] {
		PH_LINE,
		PH_BLANK,
		PH_SKIP,
		PH_NAME,
		PH_NAME_GAP,
		PH_VAL_GAP,
		PH_VAL,
		PH_AFTER,
		PH_FOLD,
		PH_BODY
	} phase_t;

	typedef enum logic [1:0] {
		KIND_FIELD,
		KIND_EOH,
		KIND_END
	} kind_t;

	typedef logic [OFFSET_BITS-1:0] off_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] name_start;
		logic [31:0] name_end;
		logic [31:0] value_start;
		logic [31:0] value_end;
		logic [31:0] next_offset;
		logic        last;
	} res_t;

	// Low 32 bits of an offset, zero-extended when offsets are narrower.
	function automatic logic [31:0] out_off(input off_t v);
		logic [OFFSET_BITS+31:0] w;
		w = {32'd0, v};
		return w[31:0];
	endfunction

	function automatic res_t mk_res(input kind_t k, input off_t ns, input off_t ne,
			input off_t vs, input off_t ve, input off_t nx);
		res_t r;
		r.kind        = k;
		r.name_start  = out_off(ns);
		r.name_end    = out_off(ne);
		r.value_start = out_off(vs);
		r.value_end   = out_off(ve);
		r.next_offset = out_off(nx);
		r.last        = 1'b0;
		return r;
	endfunction

endpackage

// File: hdl/mhfd_if.sv
// Channel interfaces: header byte stream and delimiter result stream.
`timescale 1ns / 1ps
interface mhfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;

	modport source (output valid, output data_byte, output is_last, input ready);
	modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface mhfd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] name_start;
	logic [31:0] name_end;
	logic [31:0] value_start;
	logic [31:0] value_end;
	logic [31:0] next_offset;
	logic        last;

	modport source (output valid, output kind, output name_start, output name_end,
		output value_start, output value_end, output next_offset, output last,
		input ready);
	modport sink (input valid, input kind, input name_start, input name_end,
		input value_start, input value_end, input next_offset, input last,
		output ready);
endinterface

// File: hdl/mail_header_field_delimiter_top.sv
// Top level: streaming mail header field delimiter with a small result queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage
//   stream : one header byte per item (data_byte, is_last). The first byte of a
//            buffer sits at offset 0; is_last closes the buffer.
//   result : field bounds (kind 0), end of headers (kind 1) or end of input
//            (kind 2); last marks the final result caused by one byte.
// Each accepted byte runs the line parser in the cycle it is taken and drops
// zero, one or two results into a four-entry queue.
// Throughput: one byte per cycle while the receiver keeps up. Results leave at
// one per cycle while result.ready is high, so a byte that gives two results
// keeps the output side busy for both. stream.ready needs two free queue
// entries; it drops when the receiver stalls and the queue fills, and bytes
// wait upstream meanwhile.
// Reset: parser goes to line start at offset 0, queue empties; stream.ready
// stays low until run_q is set by a clock edge after arst_n is released.
// After the last byte of a buffer all parser state returns to its reset value.
// Bytes after the end of the headers give nothing, the last byte included.
module mail_header_field_delimiter_top
	import mhfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mhfd_byte_if.sink   stream,
	mhfd_res_if.source  result
);

	// parser state
	phase_t phase_q, phase_d;
	off_t   offset_q, offset_d;
	off_t   ns_q, ns_d;
	off_t   ne_q, ne_d;
	off_t   vs_q, vs_d;
	off_t   ve_q, ve_d;
	logic   ts_q, ts_d;
	logic   run_q;

	// result queue
	res_t              q_mem [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] count_q;

	logic acc, pop;

	// per-byte working values
	logic [7:0] c;
	logic       is_lf, is_cr, is_col, is_blk;
	off_t       o, prev, nxt;
	phase_t     ph_s;      // phase after the step, before end-of-buffer handling
	off_t       ns_s, ne_s, vs_s, ve_s;
	logic       ts_s;
	logic       step_fld, step_eoh, fin_fld, fin_end;
	off_t       f1_nx;
	off_t       fvs, fve;  // value bounds of a field closed by buffer end
	res_t       rec_f1, rec_eoh, rec_f2, rec_end;
	res_t       res0, res1;
	logic [1:0] n_res;

	assign acc = stream.valid && stream.ready;
	assign pop = result.valid && result.ready;
	assign stream.ready = run_q && (count_q <= QCNT_W'(QDEPTH - 2));

	assign c      = stream.data_byte;
	assign is_lf  = (c == CH_LF);
	assign is_cr  = (c == CH_CR);
	assign is_col = (c == CH_COLON);
	assign is_blk = (c == CH_SP) || (c == CH_TAB);
	assign o      = offset_q;
	assign prev   = offset_q - 1'b1;
	assign nxt    = offset_q + 1'b1;

	// line parser: one step per byte; folded second passes are written out
	always_comb begin
		ph_s     = phase_q;
		ns_s     = ns_q;
		ne_s     = ne_q;
		vs_s     = vs_q;
		ve_s     = ve_q;
		ts_s     = ts_q;
		step_fld = 1'b0;
		step_eoh = 1'b0;
		f1_nx    = o;
		unique case (phase_q)
			PH_LINE, PH_BLANK: begin
				if (ts_q) begin
					ts_s = 1'b0;
					if (is_lf) step_eoh = 1'b1;
					else ph_s = PH_SKIP;
				end else if (is_lf) begin
					step_eoh = 1'b1;
				end else if (is_cr) begin
					ts_s = 1'b1;
				end else if (is_blk) begin
					ph_s = PH_BLANK;
				end else if (phase_q == PH_BLANK) begin
					ph_s = PH_SKIP;
				end else begin
					ns_s = o;
					if (is_col) begin
						ne_s = o;
						ph_s = PH_VAL_GAP;
					end else begin
						ph_s = PH_NAME;
					end
				end
			end
			PH_SKIP: begin
				if (is_lf) ph_s = PH_LINE;
			end
			PH_NAME: begin
				if (is_col) begin
					ne_s = o;
					ph_s = PH_VAL_GAP;
				end else if (is_blk) begin
					ne_s = o;
					ph_s = PH_NAME_GAP;
				end else if (is_lf) begin
					ph_s = PH_LINE;
				end else if (is_cr) begin
					ph_s = PH_SKIP;
				end
			end
			PH_NAME_GAP: begin
				if (is_col) ph_s = PH_VAL_GAP;
				else if (is_lf) ph_s = PH_LINE;
				else if (!is_blk) ph_s = PH_SKIP;
			end
			PH_VAL_GAP: begin
				// first value byte is parsed as value text at once
				if (!is_blk) begin
					vs_s = o;
					if (ts_q) begin
						ts_s = 1'b0;
						if (is_lf) begin
							ve_s = prev;
							ph_s = PH_AFTER;
						end else begin
							ts_s = is_cr;
							ph_s = PH_VAL;
						end
					end else if (is_lf) begin
						ve_s = o;
						ph_s = PH_AFTER;
					end else begin
						ts_s = is_cr;
						ph_s = PH_VAL;
					end
				end
			end
			PH_VAL: begin
				if (ts_q) begin
					if (is_lf) begin
						ts_s = 1'b0;
						ve_s = prev;
						ph_s = PH_AFTER;
					end else begin
						ts_s = is_cr;  // lone CR was value text
					end
				end else if (is_lf) begin
					ve_s = o;
					ph_s = PH_AFTER;
				end else if (is_cr) begin
					ts_s = 1'b1;
				end
			end
			PH_AFTER: begin
				if (is_blk) begin
					ph_s = PH_FOLD;
				end else begin
					// close the field, then this byte opens a new line
					step_fld = 1'b1;
					f1_nx    = o;
					if (ts_q) begin
						ts_s = 1'b0;
						if (is_lf) step_eoh = 1'b1;
						else ph_s = PH_SKIP;
					end else if (is_lf) begin
						step_eoh = 1'b1;
					end else if (is_cr) begin
						ts_s = 1'b1;
						ph_s = PH_LINE;
					end else begin
						ns_s = o;
						if (is_col) begin
							ne_s = o;
							ph_s = PH_VAL_GAP;
						end else begin
							ph_s = PH_NAME;
						end
					end
				end
			end
			PH_FOLD: begin
				if (ts_q) begin
					ts_s = 1'b0;
					if (is_lf) begin
						step_fld = 1'b1;
						f1_nx    = prev;
						step_eoh = 1'b1;
					end else begin
						ts_s = is_cr;
						ph_s = PH_VAL;
					end
				end else if (is_lf) begin
					step_fld = 1'b1;
					f1_nx    = o;
					step_eoh = 1'b1;
				end else if (is_cr) begin
					ts_s = 1'b1;
				end else if (!is_blk) begin
					ph_s = PH_VAL;
				end
			end
			PH_BODY: begin
			end
			default: begin
				ph_s = PH_BODY;
			end
		endcase
		if (step_eoh) begin
			ph_s = PH_BODY;
			ts_s = 1'b0;
		end
	end

	// buffer end: close an open value, or report end of input
	always_comb begin
		fin_fld = 1'b0;
		fin_end = 1'b0;
		fvs     = vs_s;
		fve     = ve_s;
		if (stream.is_last && (ph_s != PH_BODY)) begin
			case (ph_s)
				PH_VAL_GAP: begin
					fin_fld = 1'b1;
					fvs     = nxt;
					fve     = nxt;
				end
				PH_VAL: begin
					fin_fld = 1'b1;
					fve     = nxt;
				end
				PH_AFTER: begin
					fin_fld = 1'b1;
				end
				PH_FOLD: begin
					fin_fld = 1'b1;
					if (ts_s) fve = nxt;
				end
				default: begin
				end
			endcase
			fin_end = !fin_fld && !step_fld && !step_eoh;
		end
	end

	// result assembly, in order: step field, end of headers, closing field
	always_comb begin
		rec_f1  = mk_res(KIND_FIELD, ns_q, ne_q, vs_q, ve_q, f1_nx);
		rec_eoh = mk_res(KIND_EOH, '0, '0, '0, '0, nxt);
		rec_f2  = mk_res(KIND_FIELD, ns_s, ne_s, fvs, fve, nxt);
		rec_end = mk_res(KIND_END, '0, '0, '0, '0, nxt);
		n_res   = 2'(step_fld) + 2'(step_eoh) + 2'(fin_fld) + 2'(fin_end);
		if (step_fld) res0 = rec_f1;
		else if (step_eoh) res0 = rec_eoh;
		else if (fin_fld) res0 = rec_f2;
		else res0 = rec_end;
		if (step_eoh) res1 = rec_eoh;
		else res1 = rec_f2;
		res0.last = (n_res == 2'd1);
		res1.last = 1'b1;
	end

	// next parser state, with return to reset values after the last byte
	always_comb begin
		if (stream.is_last) begin
			phase_d  = PH_LINE;
			offset_d = '0;
			ns_d     = '0;
			ne_d     = '0;
			vs_d     = '0;
			ve_d     = '0;
			ts_d     = 1'b0;
		end else begin
			phase_d  = ph_s;
			offset_d = nxt;
			ns_d     = ns_s;
			ne_d     = ne_s;
			vs_d     = vs_s;
			ve_d     = ve_s;
			ts_d     = ts_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LINE;
			offset_q <= '0;
			ns_q     <= '0;
			ne_q     <= '0;
			vs_q     <= '0;
			ve_q     <= '0;
			ts_q     <= 1'b0;
			run_q    <= 1'b0;
		end else begin
			run_q <= 1'b1;
			if (acc) begin
				phase_q  <= phase_d;
				offset_q <= offset_d;
				ns_q     <= ns_d;
				ne_q     <= ne_d;
				vs_q     <= vs_d;
				ve_q     <= ve_d;
				ts_q     <= ts_d;
			end
		end
	end

	// result queue: up to two writes and one read per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (acc) wptr_q <= wptr_q + QPTR_W'(n_res);
			if (pop) rptr_q <= rptr_q + 1'b1;
			count_q <= count_q + (acc ? QCNT_W'(n_res) : '0) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (n_res != 2'd0)) begin
			q_mem[wptr_q] <= res0;
			if (n_res == 2'd2) q_mem[wptr_q + 1'b1] <= res1;
		end
	end

	assign result.valid       = (count_q != '0);
	assign result.kind        = q_mem[rptr_q].kind;
	assign result.name_start  = q_mem[rptr_q].name_start;
	assign result.name_end    = q_mem[rptr_q].name_end;
	assign result.value_start = q_mem[rptr_q].value_start;
	assign result.value_end   = q_mem[rptr_q].value_end;
	assign result.next_offset = q_mem[rptr_q].next_offset;
	assign result.last        = q_mem[rptr_q].last;

	// a pending CR only lives where a CRLF can still complete
	`MHFD_ASSERT_IMP(a_ts_phase, clk, arst_n, ts_q, (phase_q == PH_LINE) || (phase_q == PH_BLANK) || (phase_q == PH_VAL) || (phase_q == PH_FOLD))
	// offset advances by one per byte inside a buffer
	`MHFD_ASSERT_NXT(a_off_step, clk, arst_n, acc && !stream.is_last, !run_q || (offset_q == $past(offset_q) + 1'b1))
	// last byte returns the parser to line start at offset zero
	`MHFD_ASSERT_NXT(a_off_clear, clk, arst_n, acc && stream.is_last, !run_q || ((offset_q == '0) && (phase_q == PH_LINE) && !ts_q))
	// bytes after the end of the headers never add results
	`MHFD_ASSERT_NXT(a_body_quiet, clk, arst_n, acc && (phase_q == PH_BODY), !run_q || (count_q <= $past(count_q)))

endmodule
